// File: rtl/core/sync_word_frame_deframer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync word frame deframer
// Concurrent assertion helpers that fall away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SYNC_WORD_FRAME_DEFRAMER_MACROS_SVH
`define SYNC_WORD_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define SWFD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("swfd assertion failed");
// Condition must never be true outside reset.
`define SWFD_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("swfd forbidden condition seen");
`else
`define SWFD_ASSERT(lbl, clk, rstn, prop)
`define SWFD_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: rtl/core/swfd_pkg.sv
// ----------------------------------------------------------------------------
// Sync word frame deframer package
// Shared constants and types of the deframer.
// ----------------------------------------------------------------------------
package swfd_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'h5A;
  localparam int         PREFIX_LEN = 2 + 1 + 2;
  localparam int         CHECK_LEN  = 2;
  localparam int         RESULT_CAP = 64;
  localparam int         QUEUE_DEPTH = 4;

  // One received byte, tagged by the front with its sync match.
  typedef struct packed {
    logic [7:0] data;
    logic       is_sync;
  } swfd_item_t;

  // Queue to back-end handshake.
  typedef struct packed {
    logic       valid;
    swfd_item_t item;
  } swfd_q_out_t;

  // One emitted frame byte with its flags.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       swapped;
  } swfd_result_t;

endpackage

// File: rtl/core/swfd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swfd_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/swfd_front.sv
// ----------------------------------------------------------------------------
// Deframer front end
// Accepts received bytes, tags sync bytes and queues them for the parser.
// ----------------------------------------------------------------------------
module swfd_front import swfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output swfd_q_out_t q_o,
  input  logic        pop_i
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  swfd_item_t    slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign in_stall_o = (cnt_q == CW'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != '0);

  assign q_o.valid = (cnt_q != '0);
  assign q_o.item  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{data: data_byte_i, is_sync: (data_byte_i == SYNC_BYTE)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

// File: rtl/core/swfd_back.sv
// ----------------------------------------------------------------------------
// Deframer back end
// Window buffer, header search, checksum check and frame emission.
// ----------------------------------------------------------------------------
`include "sync_word_frame_deframer_macros.svh"

module swfd_back import swfd_pkg::*; #(
  parameter int WINDOW_BYTES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  swfd_q_out_t  q_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output swfd_result_t out_o,
  output logic         out_lir_o
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int FW = $clog2(WINDOW_BYTES + 1);
  localparam int SW = FW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_APPEND, S_CHECK, S_SCAN_RD, S_SCAN_USE,
    S_LEN_RD, S_LEN_USE, S_LEN_RD2, S_LEN_USE2,
    S_SUM_RD, S_SUM_USE, S_CK_RD, S_CK_USE, S_CK_RD2, S_CK_USE2,
    S_EMIT_RD, S_EMIT_USE, S_FINISH
  } state_e;

  state_e        state_q;
  logic [AW-1:0] head_q, idx_q;
  logic [FW-1:0] fill_q, flen_q;
  logic          prev_q, swapped_q;
  logic [7:0]    lo_q;
  logic [15:0]   sum_q;
  logic [6:0]    cnt_q;
  swfd_item_t    byte_q;
  logic          pend_v_q, out_v_q, out_lir_q;
  swfd_result_t  pend_q, out_q;

  logic [8:0]    rdata;
  logic [AW-1:0] raddr, waddr;
  logic [SW-1:0] rsum, wsum, dsum;
  logic [FW-1:0] drop_n, drop_fill;
  logic [AW-1:0] drop_head;
  logic          we, out_free, found, more_idx, out_load;
  logic [16:0]   flen17;
  logic [15:0]   le, be;
  swfd_result_t  new_res;

  // Physical address of logical window index idx_q.
  assign rsum  = SW'(head_q) + SW'(idx_q);
  assign raddr = (rsum >= SW'(WINDOW_BYTES)) ? AW'(rsum - SW'(WINDOW_BYTES)) : AW'(rsum);

  // Shared drop unit: remove drop_n bytes from the window front.
  always_comb begin
    drop_n = '0;
    case (state_q)
      S_APPEND:   drop_n = (fill_q == FW'(WINDOW_BYTES)) ? FW'(1) : '0;
      S_SCAN_USE: drop_n = found ? FW'(idx_q) - FW'(1) : fill_q - FW'(1);
      S_LEN_USE2: drop_n = FW'(1);
      S_CK_USE2:  drop_n = FW'(1);
      S_EMIT_USE: drop_n = flen_q;
      default:    drop_n = '0;
    endcase
  end

  assign dsum      = SW'(head_q) + SW'(drop_n);
  assign drop_head = (dsum >= SW'(WINDOW_BYTES)) ? AW'(dsum - SW'(WINDOW_BYTES)) : AW'(dsum);
  assign drop_fill = fill_q - drop_n;

  // Append address after a possible full-window drop.
  assign wsum  = SW'(drop_head) + SW'(drop_fill);
  assign waddr = (wsum >= SW'(WINDOW_BYTES)) ? AW'(wsum - SW'(WINDOW_BYTES)) : AW'(wsum);
  assign we    = (state_q == S_APPEND);

  swfd_ram #(.WIDTH(9), .DEPTH(WINDOW_BYTES)) u_window (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (byte_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign found    = prev_q && rdata[0];
  assign more_idx = (FW'(idx_q) + FW'(1)) < fill_q;
  assign flen17   = 17'(PREFIX_LEN + CHECK_LEN) + {1'b0, rdata[8:1], lo_q};
  assign le       = {rdata[8:1], lo_q};
  assign be       = {lo_q, rdata[8:1]};
  assign out_free = !out_v_q || !out_stall_i;
  assign pop_o    = (state_q == S_IDLE);

  // The pending result moves to the output register when a newer result
  // replaces it during emission, or when the run ends.
  assign out_load = pend_v_q && out_free &&
                    (((state_q == S_EMIT_USE) && (cnt_q < 7'(RESULT_CAP))) ||
                     (state_q == S_FINISH));

  assign new_res.data    = rdata[8:1];
  assign new_res.first   = (idx_q == '0);
  assign new_res.last    = (FW'(idx_q) == flen_q - FW'(1));
  assign new_res.swapped = swapped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      fill_q    <= '0;
      idx_q     <= '0;
      prev_q    <= 1'b0;
      swapped_q <= 1'b0;
      lo_q      <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
      flen_q    <= '0;
      byte_q    <= '0;
      pend_v_q  <= 1'b0;
      pend_q    <= '0;
      out_v_q   <= 1'b0;
      out_q     <= '0;
      out_lir_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_q     <= pend_q;
        out_lir_q <= (state_q == S_FINISH);
        out_v_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_i.valid) begin
            byte_q  <= q_i.item;
            state_q <= S_APPEND;
          end
        end
        S_APPEND: begin
          head_q  <= drop_head;
          fill_q  <= drop_fill + FW'(1);
          cnt_q   <= '0;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (fill_q < FW'(PREFIX_LEN)) begin
            state_q <= S_FINISH;
          end else begin
            idx_q   <= '0;
            prev_q  <= 1'b0;
            state_q <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_USE;
        S_SCAN_USE: begin
          if (found) begin
            head_q <= drop_head;
            fill_q <= drop_fill;
            idx_q  <= AW'(3);
            if (drop_fill < FW'(PREFIX_LEN)) begin
              state_q <= S_FINISH;
            end else begin
              state_q <= S_LEN_RD;
            end
          end else if (more_idx) begin
            prev_q  <= rdata[0];
            idx_q   <= idx_q + AW'(1);
            state_q <= S_SCAN_RD;
          end else begin
            head_q  <= drop_head;
            fill_q  <= drop_fill;
            state_q <= S_FINISH;
          end
        end
        S_LEN_RD: state_q <= S_LEN_USE;
        S_LEN_USE: begin
          lo_q    <= rdata[8:1];
          idx_q   <= AW'(4);
          state_q <= S_LEN_RD2;
        end
        S_LEN_RD2: state_q <= S_LEN_USE2;
        S_LEN_USE2: begin
          if (flen17 > 17'(WINDOW_BYTES)) begin
            head_q  <= drop_head;
            fill_q  <= drop_fill;
            state_q <= S_CHECK;
          end else if (17'(fill_q) < flen17) begin
            state_q <= S_FINISH;
          end else begin
            flen_q  <= FW'(flen17);
            sum_q   <= '0;
            idx_q   <= '0;
            state_q <= S_SUM_RD;
          end
        end
        S_SUM_RD: state_q <= S_SUM_USE;
        S_SUM_USE: begin
          sum_q <= sum_q + 16'(rdata[8:1]);
          if ((FW'(idx_q) + FW'(1)) < (flen_q - FW'(CHECK_LEN))) begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_SUM_RD;
          end else begin
            idx_q   <= AW'(flen_q - FW'(CHECK_LEN));
            state_q <= S_CK_RD;
          end
        end
        S_CK_RD: state_q <= S_CK_USE;
        S_CK_USE: begin
          lo_q    <= rdata[8:1];
          idx_q   <= AW'(flen_q - FW'(1));
          state_q <= S_CK_RD2;
        end
        S_CK_RD2: state_q <= S_CK_USE2;
        S_CK_USE2: begin
          if (sum_q == le || sum_q == be) begin
            swapped_q <= (sum_q != le);
            idx_q     <= '0;
            state_q   <= S_EMIT_RD;
          end else begin
            head_q  <= drop_head;
            fill_q  <= drop_fill;
            state_q <= S_CHECK;
          end
        end
        S_EMIT_RD: state_q <= S_EMIT_USE;
        S_EMIT_USE: begin
          if (cnt_q >= 7'(RESULT_CAP) || !pend_v_q || out_free) begin
            if (cnt_q < 7'(RESULT_CAP)) begin
              pend_q   <= new_res;
              pend_v_q <= 1'b1;
              cnt_q    <= cnt_q + 7'd1;
            end
            if (new_res.last) begin
              head_q  <= drop_head;
              fill_q  <= drop_fill;
              state_q <= S_CHECK;
            end else begin
              idx_q   <= idx_q + AW'(1);
              state_q <= S_EMIT_RD;
            end
          end
        end
        S_FINISH: begin
          if (!pend_v_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            pend_v_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;
  assign out_lir_o   = out_lir_q;

  `SWFD_ASSERT(a_fill_bound, clk_i, rst_ni, 32'(fill_q) <= WINDOW_BYTES)
  `SWFD_ASSERT(a_head_bound, clk_i, rst_ni, 32'(head_q) < WINDOW_BYTES)
  `SWFD_ASSERT(a_idle_no_pend, clk_i, rst_ni, (state_q == S_IDLE) |-> !pend_v_q)
  `SWFD_NEVER(a_cap_exceeded, clk_i, rst_ni, cnt_q > 7'(RESULT_CAP))

endmodule

// File: rtl/core/sync_word_frame_deframer.sv
// ----------------------------------------------------------------------------
// Sync word frame deframer
// Recovers checksummed frames that start with the sync word 0x5A 0x5A.
// ----------------------------------------------------------------------------
// Received bytes enter a four-item queue and are appended one at a time to a
// window buffer of WINDOW_BYTES bytes. After each append the parser hunts for
// the sync pair, reads the little-endian length, sums the frame and compares
// the sum with the trailing checksum in either byte order. Every step reads
// the window RAM one byte at a time: the header scan walks the filled window,
// and the sum and the emission each walk the frame; a mismatch repeats the
// scan after dropping one byte. Accepted frames leave byte by byte; the last
// result caused by an item carries last_in_run, so each frame byte is held
// one result back until the parser knows whether more follow. Bytes queue on
// the input while the parser is busy, and the output register lets the
// parser continue while a result waits to be taken.
module sync_word_frame_deframer import swfd_pkg::*; #(
  parameter int WINDOW_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic       first_of_frame_o,
  output logic       last_of_frame_o,
  output logic       checksum_swapped_o,
  output logic       last_in_run_o
);

  swfd_q_out_t  q;
  logic         pop;
  swfd_result_t res;

  // Front end: takes bytes and tags the sync bytes.
  swfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .q_o         (q),
    .pop_i       (pop)
  );

  // Back end: window, parser and output register.
  swfd_back #(.WINDOW_BYTES(WINDOW_BYTES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_i         (q),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res),
    .out_lir_o   (last_in_run_o)
  );

  assign frame_byte_o       = res.data;
  assign first_of_frame_o   = res.first;
  assign last_of_frame_o    = res.last;
  assign checksum_swapped_o = res.swapped;

endmodule

// File: dv/sync_word_frame_deframer_test.sv
// ----------------------------------------------------------------------------
// Sync word frame deframer testbench
// Drives received bytes through the deframer, predicts every recovered frame
// byte with an independent window model and checks each result in order.
// ----------------------------------------------------------------------------
module sync_word_frame_deframer_test;
  import swfd_pkg::*;

  localparam int WIN = 64;

  // Expected result of one emitted frame byte, with its run flag.
  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       swapped;
    logic       run_end;
  } frame_out_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] frame_byte_o;
  logic       first_of_frame_o;
  logic       last_of_frame_o;
  logic       checksum_swapped_o;
  logic       last_in_run_o;

  sync_word_frame_deframer #(.WINDOW_BYTES(WIN)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i,
    .out_valid_o, .out_stall_i, .frame_byte_o, .first_of_frame_o,
    .last_of_frame_o, .checksum_swapped_o, .last_in_run_o
  );

  // Predictor state: the window of received bytes not yet consumed.
  logic [7:0] win_q[$];
  frame_out_t expected_bytes[$];
  int         error_count = 0;

  // Idle and stall percentages of the current traffic phase.
  int send_idle_pct  = 0;
  int stall_pct      = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Sum of the first n bytes of the window, mod 65536.
  function automatic logic [15:0] window_sum(int n);
    logic [15:0] s;
    s = 16'h0;
    for (int i = 0; i < n; i++) s += 16'(win_q[i]);
    return s;
  endfunction

  // Appends one received byte and parses the window until it stalls, queueing
  // the bytes of every accepted frame.
  task automatic predict_frames(input logic [7:0] b);
    int         h, len, flen, start_cnt;
    logic [15:0] sum, le, be;
    frame_out_t r;
    start_cnt = expected_bytes.size();
    if (win_q.size() >= WIN) win_q.delete(0);
    win_q.push_back(b);
    forever begin
      if (win_q.size() < PREFIX_LEN) break;
      h = -1;
      for (int i = 0; i + 1 < win_q.size(); i++) begin
        if (win_q[i] == SYNC_BYTE && win_q[i+1] == SYNC_BYTE) begin
          h = i;
          break;
        end
      end
      if (h < 0) begin
        // No sync pair anywhere: only the last byte may still start one.
        win_q = win_q[$:$];
        break;
      end
      if (h > 0) begin
        win_q = win_q[h:$];
        if (win_q.size() < PREFIX_LEN) break;
      end
      len  = int'(win_q[3]) | (int'(win_q[4]) << 8);
      flen = PREFIX_LEN + len + CHECK_LEN;
      if (flen > WIN) begin
        // A length that cannot fit is handled as a checksum mismatch.
        win_q.delete(0);
        continue;
      end
      if (win_q.size() < flen) break;
      sum = window_sum(flen - CHECK_LEN);
      le  = {win_q[flen-1], win_q[flen-2]};
      be  = {win_q[flen-2], win_q[flen-1]};
      if (sum == le || sum == be) begin
        for (int i = 0; i < flen; i++) begin
          r.data    = win_q[i];
          r.first   = (i == 0);
          r.last    = (i == flen - 1);
          r.swapped = (sum != le);
          r.run_end = 1'b0;
          if (expected_bytes.size() - start_cnt < RESULT_CAP) expected_bytes.push_back(r);
        end
        win_q = win_q[flen:$];
      end else begin
        win_q.delete(0);
      end
    end
    if (expected_bytes.size() > start_cnt) expected_bytes[$].run_end = 1'b1;
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  // Sends one byte, with an idle gap drawn from the current phase. Valid stays
  // high across back-to-back items and drops only while the sender idles.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    predict_frames(b);
    @(negedge clk_i);
  endtask

  // Builds a frame around a random payload; the checksum is stored in either
  // byte order, or corrupted when asked.
  task automatic send_frame(input int len, input bit big_endian, input bit corrupt);
    logic [7:0]  f[$];
    logic [15:0] s;
    f = '{SYNC_BYTE, SYNC_BYTE, 8'($urandom), 8'(len), 8'(len >> 8)};
    for (int i = 0; i < len; i++) f.push_back(8'($urandom));
    s = 16'h0;
    foreach (f[i]) s += 16'(f[i]);
    if (corrupt) s ^= 16'(1 << $urandom_range(15));
    if (big_endian) begin
      f.push_back(s[15:8]);
      f.push_back(s[7:0]);
    end else begin
      f.push_back(s[7:0]);
      f.push_back(s[15:8]);
    end
    foreach (f[i]) send_byte(f[i]);
  endtask

  // Checker: every accepted result is matched against the oldest expectation.
  initial begin
    frame_out_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", frame_byte_o));
        end else begin
          e = expected_bytes[0];
          expected_bytes.delete(0);
          if (frame_byte_o !== e.data)
            report_mismatch($sformatf("frame_byte %02h, want %02h", frame_byte_o, e.data));
          if (first_of_frame_o !== e.first) report_mismatch("first_of_frame");
          if (last_of_frame_o !== e.last) report_mismatch("last_of_frame");
          if (checksum_swapped_o !== e.swapped) report_mismatch("checksum_swapped");
          if (last_in_run_o !== e.run_end) report_mismatch("last_in_run");
        end
      end
    end
  end

  // Receiver stalls are redrawn at every falling edge.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic test_directed();
    logic [7:0] long_hdr [5];
    // Largest frame that fits, a frame with an empty payload and one with the
    // checksum stored big-endian.
    send_frame(WIN - 7, 1'b0, 1'b0);
    send_frame(0, 1'b0, 1'b0);
    send_frame(3, 1'b1, 1'b0);
    // Garbage before a header and bytes with no header at all.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_frame(1, 1'b0, 1'b0);
    // Declared length too large for the window, then a corrupt frame.
    long_hdr = '{8'h5A, 8'h5A, 8'h01, 8'hFF, 8'hFF};
    foreach (long_hdr[i]) send_byte(long_hdr[i]);
    send_frame(2, 1'b0, 1'b1);
    send_frame(2, 1'b1, 1'b0);
  endtask

  task automatic test_random(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: begin
          send_byte(8'($urandom));
          sent++;
        end
        1: begin
          len = $urandom_range(8);
          send_frame(len, $urandom_range(1), 1'b1);
          sent += len + 7;
        end
        default: begin
          // Mostly short frames, now and then a large one.
          len = ($urandom_range(9) == 0) ? $urandom_range(WIN - 7) : $urandom_range(6);
          send_frame(len, $urandom_range(1), 1'b0);
          sent += len + 7;
        end
      endcase
    end
  endtask

  task automatic set_phase(input int idle_pct, input int st_pct);
    send_idle_pct = idle_pct;
    stall_pct     = st_pct;
  endtask

  initial begin
    int wait_cycles;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    set_phase(0, 0);
    test_random(66);
    set_phase(70, 0);
    test_random(66);
    set_phase(0, 70);
    test_random(66);
    set_phase(22, 22);
    test_random(66);
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (expected_bytes.size() != 0 && wait_cycles < 200000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (1000) @(negedge clk_i);
    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #40000000;
    $display("FAILURE");
    $finish;
  end

endmodule
